[sv/mvt_pkg.sv]
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared widths and types for the 4x4 matrix-vector transform engine.
// ----------------------------------------------------------------------------
package mvt_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PORT_WIDTH = 32;
  localparam int DIM        = 4;
  localparam int IDX_WIDTH  = 4;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int PAIR_WIDTH = PROD_WIDTH + 1;
  localparam int SUM_WIDTH  = PROD_WIDTH + 2;

  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_TRANSFORM = 1'b1;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;
  typedef logic signed [PAIR_WIDTH-1:0] pair_t;
  typedef logic signed [SUM_WIDTH-1:0]  sum_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
  } lane_ctl_t;

endpackage

[sv/mvt_lane.sv]
// ----------------------------------------------------------------------------
// mvt_lane
// One output row: four products, pairwise sum, final sum, shift and saturate.
// ----------------------------------------------------------------------------
module mvt_lane (
  input  logic                                  clk,
  input  mvt_pkg::lane_ctl_t                    ctl,
  input  logic [mvt_pkg::DIM*mvt_pkg::DATA_WIDTH-1:0] row,
  input  logic [mvt_pkg::DIM*mvt_pkg::DATA_WIDTH-1:0] vec,
  output mvt_pkg::data_t                        result,
  output logic                                  ovf
);

  localparam int SAT_LO = mvt_pkg::FRAC_BITS + mvt_pkg::DATA_WIDTH - 1;

  mvt_pkg::prod_t prod [mvt_pkg::DIM];
  mvt_pkg::pair_t pair0;
  mvt_pkg::pair_t pair1;
  mvt_pkg::sum_t  total;
  mvt_pkg::data_t result_next;
  logic           ovf_next;
  logic [mvt_pkg::SUM_WIDTH-1-SAT_LO:0] upper;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      for (int c = 0; c < mvt_pkg::DIM; c++) begin
        prod[c] <= $signed(row[c*mvt_pkg::DATA_WIDTH +: mvt_pkg::DATA_WIDTH])
                 * $signed(vec[c*mvt_pkg::DATA_WIDTH +: mvt_pkg::DATA_WIDTH]);
      end
    end
  end

  // stage 2: pair sums
  always_ff @(posedge clk) begin
    if (ctl.s2_en) begin
      pair0 <= mvt_pkg::PAIR_WIDTH'(prod[0]) + mvt_pkg::PAIR_WIDTH'(prod[1]);
      pair1 <= mvt_pkg::PAIR_WIDTH'(prod[2]) + mvt_pkg::PAIR_WIDTH'(prod[3]);
    end
  end

  // stage 3: full sum, floor shift, saturate
  always_comb begin
    total = mvt_pkg::SUM_WIDTH'(pair0) + mvt_pkg::SUM_WIDTH'(pair1);
    upper = total[mvt_pkg::SUM_WIDTH-1:SAT_LO];
    if ((&upper) || !(|upper)) begin
      result_next = total[SAT_LO:mvt_pkg::FRAC_BITS];
      ovf_next    = 1'b0;
    end else begin
      result_next = total[mvt_pkg::SUM_WIDTH-1]
                  ? {1'b1, {(mvt_pkg::DATA_WIDTH-1){1'b0}}}
                  : {1'b0, {(mvt_pkg::DATA_WIDTH-1){1'b1}}};
      ovf_next    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s3_en) begin
      result <= result_next;
      ovf    <= ovf_next;
    end
  end

endmodule

[sv/mvt_merge.sv]
// ----------------------------------------------------------------------------
// mvt_merge
// Output register: gathers the four lane results and combines overflow.
// ----------------------------------------------------------------------------
module mvt_merge (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [mvt_pkg::DIM*mvt_pkg::DATA_WIDTH-1:0] lane_result,
  input  logic [mvt_pkg::DIM-1:0]               lane_ovf,
  output logic [mvt_pkg::PORT_WIDTH-1:0]        out_x,
  output logic [mvt_pkg::PORT_WIDTH-1:0]        out_y,
  output logic [mvt_pkg::PORT_WIDTH-1:0]        out_z,
  output logic [mvt_pkg::PORT_WIDTH-1:0]        out_w,
  output logic                                  overflow
);

  function automatic logic [mvt_pkg::PORT_WIDTH-1:0] widen(input mvt_pkg::data_t v);
    widen = mvt_pkg::PORT_WIDTH'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= widen(lane_result[0*mvt_pkg::DATA_WIDTH +: mvt_pkg::DATA_WIDTH]);
      out_y    <= widen(lane_result[1*mvt_pkg::DATA_WIDTH +: mvt_pkg::DATA_WIDTH]);
      out_z    <= widen(lane_result[2*mvt_pkg::DATA_WIDTH +: mvt_pkg::DATA_WIDTH]);
      out_w    <= widen(lane_result[3*mvt_pkg::DATA_WIDTH +: mvt_pkg::DATA_WIDTH]);
      overflow <= |lane_ovf;
    end
  end

endmodule

[sv/matrix4_vector_transform.sv]
// ----------------------------------------------------------------------------
// matrix4_vector_transform
// Column-major 4x4 matrix times 4-vector, signed fixed point, four row lanes.
// ----------------------------------------------------------------------------
// input channel (in_valid / in_stall): op selects a matrix element load or a
// vector transform; a load writes elem_value at elem_index (column*4 + row)
// on the accepting edge and gives no result.
// output channel (out_valid / out_stall): one item per transform, out_x..out_w
// saturated to 32 bits, overflow set if any row clamped.
// pipeline: products are taken at the accepting edge, then registered pair
// sums, sum/shift/saturate, then the output register raises out_valid.
// throughput: one item per cycle unless out_stall holds the pipeline; each
// lane owns four multipliers and an adder tree, so nothing is shared between rows.
// a transform uses the matrix as it stood before any load accepted later.
// reset clears the matrix to zero and empties the pipeline.
// when out_stall is high the output item holds; earlier stages keep filling
// empty slots, and in_stall rises only once every stage holds an item.
// ----------------------------------------------------------------------------
module matrix4_vector_transform (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [0:0]  op,
  input  logic [3:0]  elem_index,
  input  logic [31:0] elem_value,
  input  logic [31:0] vec_x,
  input  logic [31:0] vec_y,
  input  logic [31:0] vec_z,
  input  logic [31:0] vec_w,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic [31:0] out_w,
  output logic        overflow
);

  localparam int DW = mvt_pkg::DATA_WIDTH;
  localparam int N  = mvt_pkg::DIM;

  mvt_pkg::data_t matrix [N*N];

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;
  logic accept;
  mvt_pkg::lane_ctl_t ctl;
  logic [N*DW-1:0] vec;
  logic [N*DW-1:0] lane_result;
  logic [N-1:0]    lane_ovf;

  assign rdy4     = !out_valid || !out_stall;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;
  assign accept   = in_valid && rdy1;

  assign ctl.s1_en = rdy1;
  assign ctl.s2_en = rdy2;
  assign ctl.s3_en = rdy3;

  assign vec = {vec_w[DW-1:0], vec_z[DW-1:0], vec_y[DW-1:0], vec_x[DW-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N*N; i++) begin
        matrix[i] <= '0;
      end
    end else if (accept && op == mvt_pkg::OP_LOAD) begin
      matrix[elem_index[mvt_pkg::IDX_WIDTH-1:0]] <= elem_value[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= accept && op == mvt_pkg::OP_TRANSFORM;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) out_valid <= v3;
    end
  end

  for (genvar r = 0; r < N; r++) begin : g_lane
    logic [N*DW-1:0] row;
    for (genvar c = 0; c < N; c++) begin : g_col
      assign row[c*DW +: DW] = matrix[c*N + r];
    end

    mvt_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .row    (row),
      .vec    (vec),
      .result (lane_result[r*DW +: DW]),
      .ovf    (lane_ovf[r])
    );
  end

  mvt_merge u_merge (
    .clk         (clk),
    .en          (rdy4),
    .lane_result (lane_result),
    .lane_ovf    (lane_ovf),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .out_w       (out_w),
    .overflow    (overflow)
  );

endmodule

[verif/matrix4_vector_transform_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_vector_transform_tb
// Self-checking bench for the 4x4 matrix-vector transform engine. A queue of
// load and transform items feeds a clocked driver with random idle gaps. The
// driver keeps a shadow matrix and computes the expected Q16.16 products with
// floor shift and saturation. A clocked monitor stalls at random and checks
// every output item against the oldest expected result.
// ----------------------------------------------------------------------------
module matrix4_vector_transform_tb;

  localparam int ACC_W = 2 * mvt_pkg::DATA_WIDTH + 2;
  localparam int RANDOM_ITEMS = 1850;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t SAT_MAX = (acc_t'(1) <<< (mvt_pkg::DATA_WIDTH - 1)) - acc_t'(1);
  localparam acc_t SAT_MIN = -(acc_t'(1) <<< (mvt_pkg::DATA_WIDTH - 1));

  typedef struct {
    logic        op;
    logic [3:0]  idx;
    logic [31:0] val;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    int          gap;
  } stim_item_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic        ovf;
  } xform_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [0:0]  op = mvt_pkg::OP_LOAD;
  logic [3:0]  elem_index = '0;
  logic [31:0] elem_value = '0;
  logic [31:0] vec_x = '0;
  logic [31:0] vec_y = '0;
  logic [31:0] vec_z = '0;
  logic [31:0] vec_w = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic [31:0] out_w;
  logic        overflow;

  stim_item_t     pending_items[$];
  xform_result_t  expected_xforms[$];
  mvt_pkg::data_t shadow_matrix[16];
  stim_item_t     cur_item;
  int             idle_cnt = 0;
  int             in_gap_max = 15;
  int             out_gap_max = 15;
  int             stall_left = 0;
  int             errors = 0;
  int             stim_count = 0;

  matrix4_vector_transform DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .elem_index (elem_index),
    .elem_value (elem_value),
    .vec_x      (vec_x),
    .vec_y      (vec_y),
    .vec_z      (vec_z),
    .vec_w      (vec_w),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .out_w      (out_w),
    .overflow   (overflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] saturate_row(input int row, input mvt_pkg::data_t v[4],
                                               inout logic ovf);
    acc_t acc;
    acc_t a;
    acc_t b;
    acc_t shifted;
    acc = '0;
    for (int c = 0; c < 4; c++) begin
      a = shadow_matrix[c * 4 + row];
      b = v[c];
      acc = acc + a * b;
    end
    shifted = acc >>> mvt_pkg::FRAC_BITS;
    if (shifted > SAT_MAX) begin
      shifted = SAT_MAX;
      ovf = 1'b1;
    end else if (shifted < SAT_MIN) begin
      shifted = SAT_MIN;
      ovf = 1'b1;
    end
    return shifted[31:0];
  endfunction

  function automatic xform_result_t mat_vec_product(input stim_item_t it);
    xform_result_t res;
    mvt_pkg::data_t v[4];
    logic ovf;
    v[0] = it.x;
    v[1] = it.y;
    v[2] = it.z;
    v[3] = it.w;
    ovf = 1'b0;
    res.x = saturate_row(0, v, ovf);
    res.y = saturate_row(1, v, ovf);
    res.z = saturate_row(2, v, ovf);
    res.w = saturate_row(3, v, ovf);
    res.ovf = ovf;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // value classes: full range, extremes, small and medium magnitudes
  function automatic int pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 0;
    if (r == 2) return 1;
    if (r < 7) return 2;
    return 3;
  endfunction

  function automatic logic [31:0] rand_q(input int mode);
    case (mode)
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 6))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          4: return 32'h0000_0001;
          5: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
      2: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      default: return $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
    endcase
  endfunction

  task automatic push_load(input logic [3:0] idx, input logic [31:0] val);
    stim_item_t it;
    it.op = mvt_pkg::OP_LOAD;
    it.idx = idx;
    it.val = val;
    it.x = $urandom;
    it.y = $urandom;
    it.z = $urandom;
    it.w = $urandom;
    it.gap = $urandom_range(0, in_gap_max);
    pending_items.push_back(it);
    stim_count++;
  endtask

  task automatic push_xform(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [31:0] w);
    stim_item_t it;
    it.op = mvt_pkg::OP_TRANSFORM;
    it.idx = 4'($urandom);
    it.val = $urandom;
    it.x = x;
    it.y = y;
    it.z = z;
    it.w = w;
    it.gap = $urandom_range(0, in_gap_max);
    pending_items.push_back(it);
    stim_count++;
  endtask

  // driver: predicts on acceptance, then presents the next item after its gap
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      idle_cnt <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (cur_item.op == mvt_pkg::OP_LOAD) begin
          shadow_matrix[cur_item.idx] = cur_item.val;
        end else begin
          expected_xforms.push_back(mat_vec_product(cur_item));
        end
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_cnt < pending_items[0].gap) begin
          in_valid <= 1'b0;
          idle_cnt <= idle_cnt + 1;
        end else begin
          cur_item = pending_items.pop_front();
          op <= cur_item.op;
          elem_index <= cur_item.idx;
          elem_value <= cur_item.val;
          vec_x <= cur_item.x;
          vec_y <= cur_item.y;
          vec_z <= cur_item.z;
          vec_w <= cur_item.w;
          in_valid <= 1'b1;
          idle_cnt <= 0;
        end
      end
    end
  end

  // monitor: checks each output item, then draws how long to stall
  always @(posedge clk) begin
    int n;
    xform_result_t exp_res;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (expected_xforms.size() == 0) begin
        $display("%0t unexpected item: actual %h %h %h %h ovf %b", $time,
                 out_x, out_y, out_z, out_w, overflow);
        errors++;
      end else begin
        exp_res = expected_xforms.pop_front();
        check_field("out_x", exp_res.x, out_x);
        check_field("out_y", exp_res.y, out_y);
        check_field("out_z", exp_res.z, out_z);
        check_field("out_w", exp_res.w, out_w);
        check_field("overflow", {31'b0, exp_res.ovf}, {31'b0, overflow});
      end
      if ($urandom_range(0, 99) == 0) begin
        out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
      end
      n = $urandom_range(0, out_gap_max);
      stall_left <= n;
      out_stall <= (n != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  initial begin
    int mat_mode;
    int vec_mode;
    int n_xf;
    for (int i = 0; i < 16; i++) shadow_matrix[i] = '0;

    // transform on the cleared matrix
    push_xform(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
    // identity
    push_load(4'd0, 32'h0001_0000);
    push_load(4'd5, 32'h0001_0000);
    push_load(4'd10, 32'h0001_0000);
    push_load(4'd15, 32'h0001_0000);
    push_xform(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
    // positive and negative clamp
    push_load(4'd0, 32'h7FFF_FFFF);
    push_xform(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
    push_load(4'd0, 32'h8000_0000);
    push_xform(32'h8000_0000, 32'h0, 32'h0, 32'h0);
    push_xform(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
    // row sum beyond 64 bits
    push_load(4'd4, 32'h8000_0000);
    push_load(4'd8, 32'h8000_0000);
    push_load(4'd12, 32'h8000_0000);
    push_xform(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_xform(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // floor of a tiny negative product
    push_load(4'd5, 32'hFFFF_FFFF);
    push_xform(32'h0, 32'h0000_0001, 32'h0, 32'h0);

    stim_count = 0;
    while (stim_count < RANDOM_ITEMS) begin
      in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      mat_mode = pick_mode();
      if ($urandom_range(0, 1) == 1) begin
        for (int i = 0; i < 16; i++) push_load(i[3:0], rand_q(mat_mode));
      end else begin
        n_xf = $urandom_range(1, 6);
        for (int i = 0; i < n_xf; i++) push_load(4'($urandom), rand_q(mat_mode));
      end
      vec_mode = pick_mode();
      n_xf = $urandom_range(5, 40);
      for (int i = 0; i < n_xf; i++) begin
        if ($urandom_range(0, 9) == 0) push_load(4'($urandom), rand_q(pick_mode()));
        push_xform(rand_q(vec_mode), rand_q(vec_mode), rand_q(vec_mode),
                   rand_q(vec_mode));
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (pending_items.size() != 0 || in_valid) @(negedge clk);
    while (expected_xforms.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
sv/mvt_pkg.sv
sv/mvt_lane.sv
sv/mvt_merge.sv
sv/matrix4_vector_transform.sv
verif/matrix4_vector_transform_tb.sv
